// ===== rtl/gfm_pkg.sv =====
// Shared types, constants and the CORDIC angle table of the geofence monitor.
`default_nettype none
package gfm_pkg;

	localparam int MaxFences   = 4;
	localparam int CordicSteps = 30;
	localparam int SqrtSteps   = 31;

	// configuration register indexes
	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_FENCE0 = 3'd1;
	localparam logic [2:0] REG_FENCE1 = 3'd2;
	localparam logic [2:0] REG_FENCE2 = 3'd3;
	localparam logic [2:0] REG_FENCE3 = 3'd4;

	// zone status codes
	localparam logic [1:0] ZONE_OUTSIDE = 2'd0;
	localparam logic [1:0] ZONE_INSIDE  = 2'd1;
	localparam logic [1:0] ZONE_ENTERED = 2'd2;
	localparam logic [1:0] ZONE_EXITED  = 2'd3;

	localparam logic signed [24:0] LAT_LIMIT   = 25'sd9000000;
	localparam logic signed [27:0] LON_HALF    = 28'sd18000000;
	localparam logic signed [27:0] LON_TURN    = 28'sd36000000;
	localparam logic signed [31:0] DEG_TO_RAD  = 32'sd12281663;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] TWO_EARTH_R = 32'sd12742000;
	localparam logic [30:0]        ONE_Q30     = 31'h40000000;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_DIFF,
		OP_WRAP,
		OP_AMUL,
		OP_ZINIT,
		OP_ROT,
		OP_SAVE,
		OP_PMUL,
		OP_HSUM,
		OP_SQINIT,
		OP_SQSTEP,
		OP_SQSAVE,
		OP_VINIT,
		OP_VEC,
		OP_DMUL,
		OP_DROUND,
		OP_UPDATE
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SCAN,
		S_DIFF,
		S_WRAP,
		S_AMUL,
		S_ZINIT,
		S_ROT,
		S_SAVE,
		S_PMUL,
		S_HSUM,
		S_SQINIT,
		S_SQSTEP,
		S_SQSAVE,
		S_VINIT,
		S_VEC,
		S_DMUL,
		S_DROUND,
		S_UPDATE,
		S_OSCAN,
		S_EMIT
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] sel;
		logic [4:0] step;
		logic [1:0] fence;
	} cmd_t;

	typedef struct packed {
		logic [3:0] en_mask;
	} status_t;

	// atan(2^-i) in Q2.30, truncated; steps 27 to 29 are rounded up
	function automatic logic [31:0] arc_tab(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/gfm_datapath.sv =====
// Datapath: config registers, fence state, shared multiplier, CORDIC and square root.
`default_nettype none
module gfm_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [62:0]         cfg_data,
	input  wire logic signed [24:0]  fix_latitude,
	input  wire logic signed [25:0]  fix_longitude,
	input  gfm_pkg::cmd_t            cmd,
	output gfm_pkg::status_t         sts,
	output logic [24:0]              distance_m,
	output logic [1:0]               zone_status,
	output logic [3:0]               visited_mask,
	output logic [31:0]              fix_total
);
	import gfm_pkg::*;

	function automatic logic signed [24:0] sat_lat(input logic signed [24:0] v);
		logic signed [24:0] r;
		if (v > LAT_LIMIT) r = LAT_LIMIT;
		else if (v < -LAT_LIMIT) r = -LAT_LIMIT;
		else r = v;
		return r;
	endfunction

	logic [3:0]         en_q;
	logic [62:0]        fence_q [MaxFences];
	logic [3:0]         inside_q;
	logic [3:0]         visited_q;
	logic [31:0]        fix_cnt_q;

	logic signed [24:0] flat_q;
	logic signed [25:0] flon_q;
	logic signed [25:0] dlat_q;
	logic signed [27:0] dlon_q;
	logic [63:0]        mul_q;
	logic               neg_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [31:0] s1_q, s2_q, c1_q, c2_q, t_q, u_q;
	logic [30:0]        h_q;
	logic [60:0]        v_q;
	logic [61:0]        r_q;
	logic [60:0]        bit_q;
	logic [30:0]        a_q;
	logic [24:0]        dist_q [MaxFences];
	logic [1:0]         zone_q [MaxFences];

	logic [62:0]        fw;
	logic signed [24:0] clat_sat;
	logic signed [25:0] clon;
	logic [11:0]        rad;
	logic [15:0]        rad10;
	logic signed [27:0] dlon_w;
	logic signed [26:0] ang;
	logic [25:0]        ang_mag;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic [63:0]        rnd;
	logic signed [33:0] rmag;
	logic signed [33:0] xs, ys, tab_w;
	logic               dir;
	logic signed [32:0] hs;
	logic [30:0]        h_n;
	logic [61:0]        trial;
	logic               now_in, was_in;

	assign fw       = fence_q[cmd.fence];
	assign clat_sat = sat_lat(fw[24:0]);
	assign clon     = fw[50:25];
	assign rad      = fw[62:51];
	assign rad10    = 16'({rad, 3'b000}) + 16'({rad, 1'b0});

	always_comb begin
		if (dlon_q >= LON_HALF) dlon_w = dlon_q - LON_TURN;
		else if (dlon_q < -LON_HALF) dlon_w = dlon_q + LON_TURN;
		else dlon_w = dlon_q;
	end

	always_comb begin
		case (cmd.sel)
			2'd0:    ang = {dlat_q[25], dlat_q};
			2'd1:    ang = dlon_q[26:0];
			2'd2:    ang = {{2{flat_q[24]}}, flat_q};
			default: ang = {{2{clat_sat[24]}}, clat_sat};
		endcase
		ang_mag = ang[26] ? 26'(-ang) : ang[25:0];
	end

	// one shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_AMUL: begin
				mul_a = signed'({6'b0, ang_mag});
				mul_b = DEG_TO_RAD;
			end
			OP_PMUL: begin
				case (cmd.sel)
					2'd0:    begin mul_a = c1_q; mul_b = c2_q; end
					2'd3:    begin mul_a = s1_q; mul_b = s1_q; end
					default: begin mul_a = t_q;  mul_b = s2_q; end
				endcase
			end
			OP_DMUL: begin
				mul_a = z_q[33] ? 32'sd0 : z_q[31:0];
				mul_b = TWO_EARTH_R;
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// angle rounding: half angles use one more shift
	assign rnd  = cmd.sel[1] ? (mul_q + 64'd32768) >> 16 : (mul_q + 64'd65536) >> 17;
	assign rmag = rnd[33:0];

	// rotation steers on the angle, vectoring on y
	assign xs    = x_q >>> cmd.step;
	assign ys    = y_q >>> cmd.step;
	assign tab_w = signed'({2'b00, arc_tab(cmd.step)});
	assign dir   = (cmd.op == OP_ROT) ? !z_q[33] : y_q[33];

	always_comb begin
		hs = $signed({u_q[31], u_q}) + $signed({t_q[31], t_q});
		if (hs[32]) h_n = '0;
		else if (hs > 33'sd1073741824) h_n = ONE_Q30;
		else h_n = hs[30:0];
	end

	assign trial  = r_q + {1'b0, bit_q};
	assign now_in = dist_q[cmd.fence] <= {9'b0, rad10};
	assign was_in = inside_q[cmd.fence];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= '0;
			inside_q  <= '0;
			visited_q <= '0;
			fix_cnt_q <= '0;
			for (int i = 0; i < MaxFences; i++) fence_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE: en_q       <= cfg_data[3:0];
					REG_FENCE0: fence_q[0] <= cfg_data;
					REG_FENCE1: fence_q[1] <= cfg_data;
					REG_FENCE2: fence_q[2] <= cfg_data;
					REG_FENCE3: fence_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_CAPTURE && fix_cnt_q != 32'hFFFF_FFFF)
				fix_cnt_q <= fix_cnt_q + 32'd1;
			if (cmd.op == OP_UPDATE) begin
				if (now_in && !was_in) begin
					inside_q[cmd.fence]  <= 1'b1;
					visited_q[cmd.fence] <= 1'b1;
				end else if (!now_in && was_in) begin
					inside_q[cmd.fence] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: begin
				flat_q <= sat_lat(fix_latitude);
				flon_q <= fix_longitude;
			end
			OP_DIFF: begin
				dlat_q <= $signed({clat_sat[24], clat_sat}) - $signed({flat_q[24], flat_q});
				dlon_q <= $signed({{2{clon[25]}}, clon}) - $signed({{2{flon_q[25]}}, flon_q});
			end
			OP_WRAP: dlon_q <= dlon_w;
			OP_AMUL: begin
				mul_q <= unsigned'(mul_p);
				neg_q <= ang[26];
			end
			OP_ZINIT: begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				z_q <= neg_q ? -rmag : rmag;
			end
			OP_ROT, OP_VEC: begin
				if (dir) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - tab_w;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + tab_w;
				end
			end
			OP_SAVE: begin
				case (cmd.sel)
					2'd0:    s1_q <= y_q[31:0];
					2'd1:    s2_q <= y_q[31:0];
					2'd2:    c1_q <= x_q[31:0];
					default: c2_q <= x_q[31:0];
				endcase
			end
			OP_PMUL: begin
				if (cmd.sel == 2'd3) u_q <= mul_p[61:30];
				else t_q <= mul_p[61:30];
			end
			OP_HSUM: h_q <= h_n;
			OP_SQINIT: begin
				v_q   <= cmd.sel[0] ? {ONE_Q30 - h_q, 30'b0} : {h_q, 30'b0};
				r_q   <= '0;
				bit_q <= {1'b1, 60'b0};
			end
			OP_SQSTEP: begin
				if ({1'b0, v_q} >= trial) begin
					v_q <= v_q - trial[60:0];
					r_q <= (r_q >> 1) + {1'b0, bit_q};
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_SQSAVE: if (!cmd.sel[0]) a_q <= r_q[30:0];
			OP_VINIT: begin
				x_q <= signed'({3'b000, r_q[30:0]});
				y_q <= signed'({3'b000, a_q});
				z_q <= '0;
			end
			OP_DMUL:   mul_q <= unsigned'(mul_p);
			OP_DROUND: dist_q[cmd.fence] <= 25'((mul_q + 64'd536870912) >> 30);
			OP_UPDATE: begin
				if (now_in && !was_in) zone_q[cmd.fence] <= ZONE_ENTERED;
				else if (!now_in && was_in) zone_q[cmd.fence] <= ZONE_EXITED;
				else zone_q[cmd.fence] <= now_in ? ZONE_INSIDE : ZONE_OUTSIDE;
			end
			default: ;
		endcase
	end

	assign sts.en_mask  = en_q;
	assign distance_m   = dist_q[cmd.fence];
	assign zone_status  = zone_q[cmd.fence];
	assign visited_mask = visited_q;
	assign fix_total    = fix_cnt_q;

endmodule
`default_nettype wire

// ===== rtl/gfm_ctrl.sv =====
// Controller: sequences fences, angles, products, square roots and result words.
`default_nettype none
module gfm_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire logic        out_stall,
	input  gfm_pkg::status_t sts,
	output gfm_pkg::cmd_t    cmd,
	output logic [1:0]       fence_index,
	output logic             last
);
	import gfm_pkg::*;

	localparam logic [1:0] LastFence = 2'(MaxFences - 1);
	localparam logic [4:0] RotLast   = 5'(CordicSteps - 1);
	localparam logic [4:0] SqrtLast  = 5'(SqrtSteps - 1);

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] sel_q, sel_d;
	logic [1:0] k_q, k_d;
	op_t        op;
	logic [2:0] k_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		sel_d   = sel_q;
		k_d     = k_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_CAPTURE;
					k_d     = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.en_mask[k_q]) state_d = S_DIFF;
				else if (k_q == LastFence) begin
					k_d     = '0;
					state_d = S_OSCAN;
				end else k_d = k_q + 2'd1;
			end
			S_DIFF: begin
				op      = OP_DIFF;
				cnt_d   = '0;
				state_d = S_WRAP;
			end
			S_WRAP: begin
				// two wrap passes bring any difference into range
				op = OP_WRAP;
				if (cnt_q == 5'd1) begin
					sel_d   = '0;
					state_d = S_AMUL;
				end else cnt_d = cnt_q + 5'd1;
			end
			S_AMUL: begin
				op      = OP_AMUL;
				state_d = S_ZINIT;
			end
			S_ZINIT: begin
				op      = OP_ZINIT;
				cnt_d   = '0;
				state_d = S_ROT;
			end
			S_ROT: begin
				op = OP_ROT;
				if (cnt_q == RotLast) state_d = S_SAVE;
				else cnt_d = cnt_q + 5'd1;
			end
			S_SAVE: begin
				op = OP_SAVE;
				if (sel_q == 2'd3) begin
					sel_d   = '0;
					state_d = S_PMUL;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = S_AMUL;
				end
			end
			S_PMUL: begin
				op = OP_PMUL;
				if (sel_q == 2'd3) begin
					sel_d   = '0;
					state_d = S_HSUM;
				end else sel_d = sel_q + 2'd1;
			end
			S_HSUM: begin
				op      = OP_HSUM;
				sel_d   = '0;
				state_d = S_SQINIT;
			end
			S_SQINIT: begin
				op      = OP_SQINIT;
				cnt_d   = '0;
				state_d = S_SQSTEP;
			end
			S_SQSTEP: begin
				op = OP_SQSTEP;
				if (cnt_q == SqrtLast) state_d = S_SQSAVE;
				else cnt_d = cnt_q + 5'd1;
			end
			S_SQSAVE: begin
				op = OP_SQSAVE;
				if (sel_q == 2'd0) begin
					sel_d   = 2'd1;
					state_d = S_SQINIT;
				end else state_d = S_VINIT;
			end
			S_VINIT: begin
				op      = OP_VINIT;
				cnt_d   = '0;
				state_d = S_VEC;
			end
			S_VEC: begin
				op = OP_VEC;
				if (cnt_q == RotLast) state_d = S_DMUL;
				else cnt_d = cnt_q + 5'd1;
			end
			S_DMUL: begin
				op      = OP_DMUL;
				state_d = S_DROUND;
			end
			S_DROUND: begin
				op      = OP_DROUND;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				op = OP_UPDATE;
				if (k_q == LastFence) begin
					k_d     = '0;
					state_d = S_OSCAN;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = S_SCAN;
				end
			end
			S_OSCAN: begin
				if (sts.en_mask[k_q]) state_d = S_EMIT;
				else if (k_q == LastFence) state_d = S_IDLE;
				else k_d = k_q + 2'd1;
			end
			S_EMIT: begin
				if (!out_stall) begin
					if (k_q == LastFence) state_d = S_IDLE;
					else begin
						k_d     = k_q + 2'd1;
						state_d = S_OSCAN;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign cmd         = '{op: op, sel: sel_q, step: cnt_q, fence: k_q};
	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = (state_q == S_EMIT);
	assign fence_index = k_q;
	assign k_nx        = {1'b0, k_q} + 3'd1;
	assign last        = ((sts.en_mask >> k_nx) == 4'd0);

	a_emit_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sts.en_mask[k_q])
		else $error("result word for a disabled fence");

	a_cordic_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT || state_q == S_VEC) |-> (cnt_q <= RotLast))
		else $error("CORDIC step count overran");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(k_q)))
		else $error("result word moved while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again before fix finished");

endmodule
`default_nettype wire

// ===== rtl/geofence_enter_exit_monitor_top.sv =====
// Top level of the geofence enter/exit monitor.
// Input channel: one GPS fix word (fix_latitude, fix_longitude) per handshake,
// taken when in_valid is high and in_stall is low. in_stall stays high from
// the accepted fix until its last result word has been taken.
// Output channel: one result word per enabled fence, in ascending fence order,
// with last set on the highest enabled fence; a word holds while out_stall is
// high and the block simply waits.
// Each enabled fence runs through the single shared CORDIC unit (four 30-step
// rotations and one 30-step vectoring run) and the bit-serial square root (two
// 31-step runs); on top come the two scans over the fence slots and the emission
// of the result words. A fix with no fence enabled is counted and gives no words.
// Configuration writes go through cfg_we/cfg_index/cfg_data while idle; this
// binds the user, the block itself does not enforce it.
// Reset clears the configuration registers, inside and visited flags and the
// fix count.
`default_nettype none
module geofence_enter_exit_monitor_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [62:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [24:0] fix_latitude,
	input  wire logic signed [25:0] fix_longitude,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              fence_index,
	output logic [24:0]             distance_m,
	output logic [1:0]              zone_status,
	output logic [3:0]              visited_mask,
	output logic [31:0]             fix_total,
	output logic                    last
);
	import gfm_pkg::*;

	cmd_t    cmd;
	status_t sts;

	gfm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sts         (sts),
		.cmd         (cmd),
		.fence_index (fence_index),
		.last        (last)
	);

	gfm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fix_latitude  (fix_latitude),
		.fix_longitude (fix_longitude),
		.cmd           (cmd),
		.sts           (sts),
		.distance_m    (distance_m),
		.zone_status   (zone_status),
		.visited_mask  (visited_mask),
		.fix_total     (fix_total)
	);

endmodule
`default_nettype wire
